### sv/gwr_pkg.sv
// Shared types and constants of the greedy word wrapper.
package gwr_pkg;

    localparam logic [7:0] BYTE_SPACE   = 8'd32;
    localparam logic [7:0] BYTE_NEWLINE = 8'd10;
    localparam logic [7:0] WIDTH_RESET  = 8'd110;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_EOL  = 1'b1;

    // Command queue between the front and back parts.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PW    = 2;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic       item_kind;
        logic [7:0] out_byte;
        logic       word_cut;
        logic       run_last;
    } out_item_t;

    // What goes in front of a word: nothing, a space, one or two line ends.
    typedef enum logic [1:0] {
        LEAD_NONE  = 2'd0,
        LEAD_SPACE = 2'd1,
        LEAD_EOL   = 2'd2,
        LEAD_EOL2  = 2'd3
    } lead_t;

    typedef struct packed {
        lead_t lead;
        logic  word_cut;
        logic  bank;
        logic  tail;
    } gwr_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LEAD = 4'b0010,
        ST_WORD = 4'b0100,
        ST_TAIL = 4'b1000
    } back_state_t;

endpackage

### sv/gwr_fifo.sv
// Small command queue between the front and back parts of the wrapper.
module gwr_fifo
    import gwr_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    logic [WIDTH-1:0]   slot_reg [FIFO_DEPTH];
    logic [FIFO_PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_PW:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full     = (count_reg == (FIFO_PW+1)'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### sv/gwr_front.sv
// Front part: accepts bytes, collects words, makes the wrap decisions.
module gwr_front
    import gwr_pkg::*;
#(
    parameter int MAX_WORD = 32,
    parameter int IDXW     = 5,
    parameter int LENW     = 6
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  in_item_t        s_data,
    input  logic            cfg_valid,
    input  logic            cfg_ready,
    input  logic [7:0]      cfg_data,
    input  logic            fifo_full,
    output logic            cmd_push,
    output gwr_cmd_t        cmd,
    output logic [LENW-1:0] cmd_len,
    output logic            wr_en,
    output logic [IDXW:0]   wr_addr,
    output logic [7:0]      wr_data,
    input  logic            word_done
);

    logic [7:0]      line_width_reg;
    logic [7:0]      line_len_reg, line_len_next;
    logic [LENW-1:0] word_len_reg, word_len_next;
    logic            ovf_reg, ovf_next;
    logic            para_reg, para_next;
    logic            wbank_reg;
    logic [1:0]      pending_reg, pending_next;

    logic            is_nl, is_sp, is_chr, room, finish, has_word, para_nl, fits, acc;
    logic [LENW-1:0] wl_eff;
    logic            ovf_eff;
    logic [8:0]      fit_sum;
    logic [7:0]      line_after;
    lead_t           lead;
    logic            tail;

    always_comb begin
        is_nl    = (s_data.text_byte == BYTE_NEWLINE);
        is_sp    = (s_data.text_byte == BYTE_SPACE);
        is_chr   = !is_nl && !is_sp;
        room     = (word_len_reg < LENW'(MAX_WORD));
        wl_eff   = (is_chr && room) ? word_len_reg + 1'b1 : word_len_reg;
        ovf_eff  = ovf_reg | (is_chr & ~room);
        para_nl  = is_nl && !para_reg;
        finish   = is_sp || (is_nl && para_reg) || s_data.end_of_text;
        has_word = finish && (wl_eff != '0);
        fit_sum  = 9'(line_len_reg) + 9'(wl_eff) + 9'd1;
        fits     = (fit_sum <= {1'b0, line_width_reg});

        lead       = LEAD_NONE;
        line_after = line_len_reg;
        if (para_nl) begin
            lead       = (line_len_reg != '0) ? LEAD_EOL2 : LEAD_EOL;
            line_after = '0;
        end else if (has_word) begin
            line_after = 8'(wl_eff);
            if (line_len_reg != '0) begin
                if (fits) begin
                    lead       = LEAD_SPACE;
                    line_after = fit_sum[7:0];
                end else begin
                    lead = LEAD_EOL;
                end
            end
        end
        tail = s_data.end_of_text && (line_after != '0);

        // Both word banks busy means the next character has nowhere to go.
        s_ready  = !fifo_full && (pending_reg != 2'd2);
        acc      = s_valid && s_ready;
        cmd_push = acc && ((lead != LEAD_NONE) || has_word || tail);

        cmd.lead     = lead;
        cmd.word_cut = ovf_eff;
        cmd.bank     = wbank_reg;
        cmd.tail     = tail;
        cmd_len      = has_word ? wl_eff : '0;

        wr_en   = acc && is_chr && room;
        wr_addr = {wbank_reg, word_len_reg[IDXW-1:0]};
        wr_data = s_data.text_byte;

        line_len_next = line_len_reg;
        word_len_next = word_len_reg;
        ovf_next      = ovf_reg;
        para_next     = para_reg;
        if (acc) begin
            if (s_data.end_of_text) begin
                line_len_next = '0;
                word_len_next = '0;
                ovf_next      = 1'b0;
                para_next     = 1'b0;
            end else begin
                line_len_next = line_after;
                word_len_next = finish ? '0 : wl_eff;
                ovf_next      = finish ? 1'b0 : ovf_eff;
                para_next     = !is_nl;
            end
        end

        pending_next = pending_reg;
        if ((acc && has_word) && !word_done) begin
            pending_next = pending_reg + 1'b1;
        end else if (!(acc && has_word) && word_done) begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg <= WIDTH_RESET;
            line_len_reg   <= '0;
            word_len_reg   <= '0;
            ovf_reg        <= 1'b0;
            para_reg       <= 1'b0;
            wbank_reg      <= 1'b0;
            pending_reg    <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                line_width_reg <= cfg_data;
            end
            line_len_reg <= line_len_next;
            word_len_reg <= word_len_next;
            ovf_reg      <= ovf_next;
            para_reg     <= para_next;
            pending_reg  <= pending_next;
            if (acc && has_word) begin
                wbank_reg <= ~wbank_reg;
            end
        end
    end

endmodule

### sv/gwr_back.sv
// Back part: holds the word memory and plays commands out as result transfers.
module gwr_back
    import gwr_pkg::*;
#(
    parameter int IDXW = 5,
    parameter int LENW = 6
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            fifo_empty,
    output logic            cmd_pop,
    input  gwr_cmd_t        cmd,
    input  logic [LENW-1:0] cmd_len,
    input  logic            wr_en,
    input  logic [IDXW:0]   wr_addr,
    input  logic [7:0]      wr_data,
    output logic            word_done,
    output logic            m_valid,
    input  logic            m_ready,
    output out_item_t       m_data
);

    localparam int MemDepth = 2 ** (IDXW + 1);

    logic [7:0]      word_mem [MemDepth];
    logic [7:0]      rdata_reg;
    back_state_t     state_reg, state_next;
    gwr_cmd_t        cur_reg, cur_next;
    logic [LENW-1:0] len_reg, len_next;
    logic [IDXW:0]   rd_ptr_reg, rd_ptr_next;
    logic            m_valid_reg;
    out_item_t       m_data_reg, emit_data;
    logic            emit, load_ok, at_end;
    back_state_t     after_lead;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign load_ok = !m_valid_reg || m_ready;
    assign at_end  = (LENW'(rd_ptr_reg[IDXW-1:0]) + 1'b1 == len_reg);

    always_comb begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        len_next    = len_reg;
        rd_ptr_next = rd_ptr_reg;
        cmd_pop     = 1'b0;
        emit        = 1'b0;
        emit_data   = '0;
        word_done   = 1'b0;

        if (len_reg != '0) begin
            after_lead = ST_WORD;
        end else if (cur_reg.tail) begin
            after_lead = ST_TAIL;
        end else begin
            after_lead = ST_IDLE;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (!fifo_empty) begin
                    cmd_pop     = 1'b1;
                    cur_next    = cmd;
                    len_next    = cmd_len;
                    rd_ptr_next = {cmd.bank, {IDXW{1'b0}}};
                    state_next  = ST_LEAD;
                end
            end
            ST_LEAD: begin
                unique case (cur_reg.lead)
                    LEAD_NONE: begin
                        state_next = after_lead;
                    end
                    LEAD_SPACE, LEAD_EOL: begin
                        if (load_ok) begin
                            emit                = 1'b1;
                            emit_data.item_kind = (cur_reg.lead == LEAD_EOL) ? KIND_EOL
                                                                            : KIND_CHAR;
                            emit_data.out_byte  = (cur_reg.lead == LEAD_EOL) ? 8'd0
                                                                            : BYTE_SPACE;
                            emit_data.run_last  = (after_lead == ST_IDLE);
                            state_next          = after_lead;
                        end
                    end
                    LEAD_EOL2: begin
                        if (load_ok) begin
                            emit                = 1'b1;
                            emit_data.item_kind = KIND_EOL;
                            emit_data.run_last  = 1'b0;
                            cur_next.lead       = LEAD_EOL;
                        end
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_WORD: begin
                if (load_ok) begin
                    emit                = 1'b1;
                    emit_data.item_kind = KIND_CHAR;
                    emit_data.out_byte  = rdata_reg;
                    emit_data.word_cut  = cur_reg.word_cut;
                    emit_data.run_last  = at_end && !cur_reg.tail;
                    if (at_end) begin
                        word_done  = 1'b1;
                        state_next = cur_reg.tail ? ST_TAIL : ST_IDLE;
                    end else begin
                        rd_ptr_next = rd_ptr_reg + {{IDXW{1'b0}}, 1'b1};
                    end
                end
            end
            ST_TAIL: begin
                if (load_ok) begin
                    emit                = 1'b1;
                    emit_data.item_kind = KIND_EOL;
                    emit_data.run_last  = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The memory is read at the next read address, so rdata_reg holds the current character.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            word_mem[wr_addr] <= wr_data;
        end
        rdata_reg <= word_mem[rd_ptr_next];
    end

    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        len_reg    <= len_next;
        rd_ptr_reg <= rd_ptr_next;
        if (emit) begin
            m_data_reg <= emit_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

### sv/greedy_word_wrapper_top.sv
// Top level of the greedy word wrapper: front part, command queue and back part.
//
// Text enters one byte per transfer on the s_ channel (valid/ready); the final byte of a
// text carries end_of_text. Wrapped lines leave on the m_ channel, one character or one
// end-of-line mark per transfer, with run_last set on the last result of each input byte.
// The line width, reset to 110, is written through the cfg_ channel, which is always ready;
// the user must write it only while the block is idle, which the block does not enforce.
// The front part takes one byte per cycle while it is ready, stores word characters in a
// two-bank word memory and turns each byte that ends a word, a paragraph or the text into
// at most one command. It holds off input while the command queue is full or both word
// banks still wait to be read out.
// The back part takes one command from the queue and then puts out one result per cycle
// while the output register is free to load. A command with no space or line end in front
// first passes its lead state without a result. A byte's first result goes through the
// command queue, the back part's command register and then the output register.
// A stalled receiver holds the output register; the back part then waits, while the
// front part keeps taking bytes until the queue or the word banks fill up.
// Reset (aresetn low at a clock edge) empties the queue, clears line, word and paragraph
// state and drops m_valid. The word memory needs no clearing.
module greedy_word_wrapper_top
    import gwr_pkg::*;
#(
    parameter int MAX_WORD = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [7:0] cfg_data
);

    // Index width into one word bank and width of a word length up to MAX_WORD.
    localparam int IDXW   = $clog2(MAX_WORD);
    localparam int LENW   = $clog2(MAX_WORD + 1);
    localparam int QWIDTH = $bits(gwr_cmd_t) + LENW;

    logic            fifo_full, fifo_empty, cmd_push, cmd_pop;
    gwr_cmd_t        push_cmd, pop_cmd;
    logic [LENW-1:0] push_len, pop_len;
    logic            wr_en, word_done;
    logic [IDXW:0]   wr_addr;
    logic [7:0]      wr_data;

    // The line width register accepts a write in every cycle.
    assign cfg_ready = 1'b1;

    gwr_front #(
        .MAX_WORD (MAX_WORD),
        .IDXW     (IDXW),
        .LENW     (LENW)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .fifo_full (fifo_full),
        .cmd_push  (cmd_push),
        .cmd       (push_cmd),
        .cmd_len   (push_len),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .word_done (word_done)
    );

    gwr_fifo #(
        .WIDTH (QWIDTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (cmd_push),
        .push_data ({push_cmd, push_len}),
        .full      (fifo_full),
        .pop       (cmd_pop),
        .pop_data  ({pop_cmd, pop_len}),
        .empty     (fifo_empty)
    );

    gwr_back #(
        .IDXW (IDXW),
        .LENW (LENW)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fifo_empty (fifo_empty),
        .cmd_pop    (cmd_pop),
        .cmd        (pop_cmd),
        .cmd_len    (pop_len),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .word_done  (word_done),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

### tb/greedy_word_wrapper_top_test.sv
// Testbench of the greedy word wrapper: directed and random text checked against a wrap predictor.
module greedy_word_wrapper_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import gwr_pkg::*;

    localparam int MAX_WORD      = 32;
    localparam int MAX_GAP       = 10;
    // Cycles allowed after the last expected result before the block counts as idle.
    localparam int SETTLE_CYCLES = 24;
    // Length of the one long receiver stall that backs the block up to its input.
    localparam int LONG_HOLD     = 300;
    // Worst case is far below this: a few hundred bytes, each with up to 34 results
    // that each wait out a random receiver stall, plus the long hold.
    localparam int CYCLE_LIMIT   = 600000;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    in_item_t   s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    out_item_t  m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data  = 8'd0;

    // Idling switches for the sender and the receiver; the tests flip them per phase.
    bit tx_idle      = 1'b1;
    bit rx_idle      = 1'b1;
    int hold_request = 0;

    int err_count   = 0;
    int cycle_count = 0;
    int n_bytes     = 0;
    int n_results   = 0;
    int n_eol       = 0;
    int n_cut       = 0;

    // Predictor state: a private copy of the width register and of the wrap state.
    logic [7:0] width_q   = WIDTH_RESET;
    int         line_len  = 0;
    logic [7:0] word_mem [MAX_WORD];
    int         word_len  = 0;
    bit         word_ovf  = 1'b0;
    bit         para_busy = 1'b0;

    // Results that the predictor has worked out and the block has not yet delivered.
    out_item_t line_out_due[$];
    // Text waiting to be sent by the current test.
    in_item_t  text_q[$];

    greedy_word_wrapper_top #(
        .MAX_WORD(MAX_WORD)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #5 aclk = ~aclk;

    // A hard ceiling on the run, so that a hung handshake cannot stall the simulation.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, line_out_due.size());
            $display("greedy_word_wrapper_top_test: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic void push_result(logic kind, logic [7:0] value, logic cut);
        out_item_t r;
        r.item_kind = kind;
        r.out_byte  = value;
        r.word_cut  = cut;
        r.run_last  = 1'b0;
        line_out_due.insert(line_out_due.size(), r);
    endfunction

    // Closes the pending word: it goes after a space if the line still fits,
    // otherwise the line is ended first. An empty word produces nothing.
    function automatic void place_word();
        int i;
        if (word_len == 0)
            return;
        if (line_len != 0) begin
            if (line_len + 1 + word_len <= int'(width_q)) begin
                push_result(KIND_CHAR, BYTE_SPACE, 1'b0);
                line_len += 1;
            end else begin
                push_result(KIND_EOL, 8'd0, 1'b0);
                line_len = 0;
            end
        end
        for (i = 0; i < word_len; i++)
            push_result(KIND_CHAR, word_mem[i], word_ovf);
        line_len = (line_len + word_len) & 255;
        word_len = 0;
        word_ovf = 1'b0;
    endfunction

    // Works out every result that one accepted byte causes.
    function automatic void wrap_byte(in_item_t item);
        int        n_before;
        int        last_idx;
        out_item_t r;
        n_before = line_out_due.size();
        if (item.text_byte == BYTE_NEWLINE) begin
            // Only a newline that closes an empty paragraph breaks the line,
            // and it adds a blank line.
            if (!para_busy) begin
                if (line_len != 0)
                    push_result(KIND_EOL, 8'd0, 1'b0);
                push_result(KIND_EOL, 8'd0, 1'b0);
                line_len = 0;
            end else begin
                place_word();
            end
            para_busy = 1'b0;
        end else begin
            para_busy = 1'b1;
            if (item.text_byte == BYTE_SPACE) begin
                place_word();
            end else if (word_len < MAX_WORD) begin
                word_mem[word_len] = item.text_byte;
                word_len++;
            end else begin
                word_ovf = 1'b1;
            end
        end
        if (item.end_of_text) begin
            place_word();
            if (line_len != 0)
                push_result(KIND_EOL, 8'd0, 1'b0);
            line_len  = 0;
            word_len  = 0;
            word_ovf  = 1'b0;
            para_busy = 1'b0;
        end
        if (line_out_due.size() > n_before) begin
            last_idx = line_out_due.size() - 1;
            r = line_out_due[last_idx];
            r.run_last = 1'b1;
            line_out_due[last_idx] = r;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= 40)
            $display("%0t ns: mismatch at result %0d: %s", $realtime, n_results, what);
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        n_results++;
        if (got.item_kind == KIND_EOL)
            n_eol++;
        if (got.word_cut)
            n_cut++;
        if (line_out_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", got));
        end else begin
            want = line_out_due.pop_front();
            if (got.item_kind !== want.item_kind)
                report_mismatch($sformatf("item_kind %b, expected %b",
                                          got.item_kind, want.item_kind));
            if (got.out_byte !== want.out_byte)
                report_mismatch($sformatf("out_byte %h, expected %h",
                                          got.out_byte, want.out_byte));
            if (got.word_cut !== want.word_cut)
                report_mismatch($sformatf("word_cut %b, expected %b",
                                          got.word_cut, want.word_cut));
            if (got.run_last !== want.run_last)
                report_mismatch($sformatf("run_last %b, expected %b",
                                          got.run_last, want.run_last));
        end
    endtask

    // Every result transfer is checked against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            check_result(m_data);
    end

    // Result receiver. Before each transfer it may hold m_ready low for a random
    // number of cycles. A hold request from a test replaces that draw once, so the
    // receiver then stalls for a long stretch that it counts itself.
    initial begin : result_sink
        int gap;
        forever begin
            gap = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (hold_request > 0) begin
                gap = hold_request;
                hold_request = 0;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Sends one byte: an optional random gap with s_valid low, then s_valid stays
    // high until the transfer. The byte enters the predictor once it is accepted.
    // s_valid is left high, so back-to-back bytes keep it up without a dip.
    task automatic send_byte(input in_item_t item);
        int gap;
        gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!(s_valid && s_ready));
        wrap_byte(item);
        n_bytes++;
    endtask

    task automatic send_queued();
        while (text_q.size() > 0)
            send_byte(text_q.pop_front());
    endtask

    // Drops s_valid and waits until every expected result has arrived, then lets
    // the block settle in case a byte with no results is still being worked on.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (line_out_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes the line width; only called while the block is idle.
    task automatic set_width(input logic [7:0] width);
        cfg_valid <= 1'b1;
        cfg_data  <= width;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        width_q = width;
    endtask

    task automatic add_byte(input logic [7:0] value, input logic eot);
        in_item_t item;
        item.text_byte   = value;
        item.end_of_text = eot;
        text_q.insert(text_q.size(), item);
    endtask

    task automatic add_string(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            add_byte(s[i], 1'b0);
    endtask

    // Marks the last queued byte as the end of the text.
    task automatic mark_end();
        in_item_t item;
        int       last_idx;
        last_idx = text_q.size() - 1;
        item = text_q[last_idx];
        item.end_of_text = 1'b1;
        text_q[last_idx] = item;
    endtask

    function automatic logic [7:0] word_char();
        logic [7:0] v;
        do v = 8'($urandom_range(0, 255));
        while (v == BYTE_SPACE || v == BYTE_NEWLINE);
        return v;
    endfunction

    // Queues one text of about n_bytes_wanted bytes. Most of it is words of random
    // characters with their separators; the rest is stray spaces, newlines and
    // arbitrary bytes. Words past MAX_WORD show up now and then when allowed.
    task automatic add_random_text(input int n_bytes_wanted, input bit long_words);
        int start;
        int len;
        int i;
        int pick;
        start = text_q.size();
        while (text_q.size() - start < n_bytes_wanted) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                if (long_words && $urandom_range(0, 5) == 0)
                    len = $urandom_range(MAX_WORD + 1, MAX_WORD + 6);
                else
                    len = $urandom_range(1, 10);
                for (i = 0; i < len; i++)
                    add_byte(word_char(), 1'b0);
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    add_byte(BYTE_SPACE, 1'b0);
                end else if (pick < 75) begin
                    add_byte(BYTE_NEWLINE, 1'b0);
                end else if (pick < 85) begin
                    add_byte(BYTE_SPACE, 1'b0);
                    add_byte(BYTE_SPACE, 1'b0);
                end
            end else if (pick < 85) begin
                add_byte(BYTE_NEWLINE, 1'b0);
            end else if (pick < 92) begin
                add_byte(BYTE_SPACE, 1'b0);
            end else begin
                add_byte(8'($urandom_range(0, 255)), 1'b0);
            end
        end
        mark_end();
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset width of 110. Covers a doubled space (an empty word), the extreme
    // byte values 0x00 and 0xFF, a carriage return as a plain word character,
    // and the end of text falling on a space.
    task automatic test_default_width();
        add_string("ab");
        add_byte(BYTE_SPACE, 1'b0);
        add_byte(BYTE_SPACE, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h0D, 1'b0);
        add_byte(BYTE_SPACE, 1'b1);
        send_queued();
        wait_idle();
    endtask

    // Paragraph handling: a newline on an empty paragraph at the start, a newline
    // that only closes a word, an empty paragraph after a finished line (line end
    // plus blank line), a spaces-only paragraph that adds no blank line, and a
    // newline as the final byte of the text.
    task automatic test_paragraph_breaks();
        add_byte(BYTE_NEWLINE, 1'b0);
        add_string("x");
        add_byte(BYTE_NEWLINE, 1'b0);
        add_byte(BYTE_NEWLINE, 1'b0);
        add_byte(BYTE_SPACE, 1'b0);
        add_byte(BYTE_NEWLINE, 1'b0);
        add_string("y");
        add_byte(BYTE_NEWLINE, 1'b1);
        send_queued();
        wait_idle();
    endtask

    // With a width of zero every word after the first goes onto a new line.
    task automatic test_zero_width();
        set_width(8'd0);
        add_string("a b c");
        mark_end();
        send_queued();
        wait_idle();
    endtask

    // Random text at several widths, the extremes among them. Each phase uses a
    // different mix of sender and receiver idling, one with none at all.
    task automatic test_random_widths();
        logic [7:0] widths [4];
        int p;
        int t;
        widths[0] = 8'd1;
        widths[1] = 8'd255;
        widths[2] = 8'd7;
        widths[3] = 8'($urandom_range(1, 255));
        for (p = 0; p < 4; p++) begin
            set_width(widths[p]);
            tx_idle = (p == 0 || p == 2);
            rx_idle = (p == 0 || p == 3);
            for (t = 0; t < 3; t++)
                add_random_text(8, 1'b0);
            send_queued();
            wait_idle();
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // Words past the word buffer: one forced overlong word, then random text
    // that allows long words. The kept part must still fit-test correctly.
    task automatic test_long_words();
        int i;
        set_width(8'd40);
        for (i = 0; i < MAX_WORD + 4; i++)
            add_byte(word_char(), 1'b0);
        add_byte(BYTE_SPACE, 1'b0);
        add_string("ok");
        mark_end();
        add_random_text(15, 1'b1);
        send_queued();
        wait_idle();
    endtask

    // The receiver stalls for a long stretch after its next transfer while the
    // sender keeps offering bytes back to back, so the command queue and word
    // banks fill up and s_ready has to drop.
    task automatic test_backpressure();
        set_width(8'd16);
        tx_idle = 1'b0;
        hold_request = LONG_HOLD;
        add_random_text(25, 1'b0);
        send_queued();
        wait_idle();
        tx_idle = 1'b1;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_width();
        test_paragraph_breaks();
        test_zero_width();
        test_random_widths();
        test_long_words();
        test_backpressure();

        // Everything has been accepted and every expected result has come back;
        // wait_idle above already gave the block time to show any stray result.
        $display("Sent %0d text bytes at widths 110, 0, 1, 255, 7, 40, 16 and one random.",
                 n_bytes);
        $display("Checked %0d results: %0d line ends, %0d truncated-word characters.",
                 n_results, n_eol, n_cut);
        if (err_count == 0 && line_out_due.size() == 0) begin
            $display("greedy_word_wrapper_top_test: clean");
        end else begin
            $display("greedy_word_wrapper_top_test: errors");
        end
        $finish;
    end

endmodule
